### rtl/ctok_pkg.sv
// Shared types, codes and constants for the C subset tokenizer.
package ctok_pkg;

    // Default values for the top-level parameters
    localparam int DEF_KEYWORD_SLOTS     = 4;
    localparam int DEF_MAX_KEYWORD_CHARS = 8;
    localparam int DEF_POS_WIDTH         = 32;
    localparam int DEF_VALUE_WIDTH       = 32;

    // Field widths of the token beat
    localparam int KIND_W  = 4;
    localparam int START_W = 32;
    localparam int LEN_W   = 16;
    localparam int SLOT_W  = 2;
    localparam int VALUE_W = 32;

    // Configuration port
    localparam int KEYWORD_REGS = 4;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 64;
    localparam int KW_COUNT_W   = 3;

    localparam logic [CFG_IDX_W-1:0] REG_KEYWORD_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEYWORD_A     = 3'd1;

    // Result queue
    localparam int QUEUE_DEPTH = 8;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int MAX_RESULTS = 3;

    // Characters with a meaning of their own
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_LOW_A  = 8'h61;
    localparam logic [7:0] CH_LOW_Z  = 8'h7A;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_Z   = 8'h5A;

    // Token kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_SEMI    = 4'd0,
        KIND_LBRACE  = 4'd1,
        KIND_RBRACE  = 4'd2,
        KIND_LPAREN  = 4'd3,
        KIND_RPAREN  = 4'd4,
        KIND_CONST   = 4'd5,
        KIND_IDENT   = 4'd6,
        KIND_KEYWORD = 4'd7,
        KIND_END     = 4'd8,
        KIND_BADNUM  = 4'd9,
        KIND_BADCHAR = 4'd10
    } t_kind;

    // One result beat as it sits in the queue
    typedef struct packed {
        t_kind              kind;
        logic [START_W-1:0] start_pos;
        logic [LEN_W-1:0]   length;
        logic [SLOT_W-1:0]  keyword_slot;
        logic [VALUE_W-1:0] const_value;
        logic               run_end;
    } t_token;

endpackage

### rtl/ctok_in_if.sv
// Character channel: one source character per beat.
interface ctok_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       final_char;

    modport source (output valid, output ch, output final_char, input ready);
    modport sink   (input valid, input ch, input final_char, output ready);
endinterface

### rtl/ctok_out_if.sv
// Token channel: one token per beat.
interface ctok_out_if;
    logic                          valid;
    logic                          ready;
    logic [ctok_pkg::KIND_W-1:0]   kind;
    logic [ctok_pkg::START_W-1:0]  start_pos;
    logic [ctok_pkg::LEN_W-1:0]    length;
    logic [ctok_pkg::SLOT_W-1:0]   keyword_slot;
    logic [ctok_pkg::VALUE_W-1:0]  const_value;
    logic                          run_end;

    modport source (output valid, output kind, output start_pos, output length,
                    output keyword_slot, output const_value, output run_end, input ready);
    modport sink   (input valid, input kind, input start_pos, input length,
                    input keyword_slot, input const_value, input run_end, output ready);
endinterface

### rtl/c_subset_tokenizer.sv
// Streaming tokenizer for a small C subset: top level with scanner and token queue.
//
//   Channel   Dir   Beat contents                                   Handshake
//   i_in      in    ch, final_char                                  valid/ready
//   o_out     out   kind, start_pos, length, keyword_slot,          valid/ready
//                   const_value, run_end
//   i_cfg_*   in    register index, write data                      write enable
//
// A character is scanned in the cycle it is accepted; its zero to three tokens enter
// an eight-entry queue at the next edge, and leave it one per cycle of output ready.
// Input ready depends only on the queue fill: it is high while at least three entries
// are free, so one character per cycle is sustained as long as tokens drain at the
// same pace. Output stalls back up into the queue and reach the input at six entries.
// Reset is synchronous; the block takes characters from the first cycle after it.
module c_subset_tokenizer #(
    parameter int KEYWORD_SLOTS     = ctok_pkg::DEF_KEYWORD_SLOTS,
    parameter int MAX_KEYWORD_CHARS = ctok_pkg::DEF_MAX_KEYWORD_CHARS,
    parameter int POS_WIDTH         = ctok_pkg::DEF_POS_WIDTH,
    parameter int VALUE_WIDTH       = ctok_pkg::DEF_VALUE_WIDTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    ctok_in_if.sink                             i_in,
    ctok_out_if.source                          o_out,
    input  logic                                i_cfg_we,
    input  logic [ctok_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [ctok_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int KW_REGS = (KEYWORD_SLOTS < ctok_pkg::KEYWORD_REGS) ?
                             KEYWORD_SLOTS : ctok_pkg::KEYWORD_REGS;
    localparam int KW_BITS = MAX_KEYWORD_CHARS * 8;
    localparam int LEN_W   = ctok_pkg::LEN_W;
    localparam int QPTR_W  = ctok_pkg::QPTR_W;
    localparam int QCNT_W  = ctok_pkg::QCNT_W;
    localparam int NRES    = ctok_pkg::MAX_RESULTS;

    // Scanner modes
    typedef enum logic [7:0] {
        MODE_NORMAL = 8'b0000_0001,
        MODE_SLASH  = 8'b0000_0010,
        MODE_LINE   = 8'b0000_0100,
        MODE_BLOCK  = 8'b0000_1000,
        MODE_BSTAR  = 8'b0001_0000,
        MODE_IDENT  = 8'b0010_0000,
        MODE_NUMBER = 8'b0100_0000,
        MODE_ERROR  = 8'b1000_0000
    } t_mode;

    // Configuration registers
    logic [ctok_pkg::KW_COUNT_W-1:0]  r_kw_count;
    logic [ctok_pkg::CFG_DATA_W-1:0]  r_kw [KW_REGS];

    // Scanner state
    t_mode                  r_mode,   n_mode;
    logic [POS_WIDTH-1:0]   r_pos,    n_pos;
    logic [POS_WIDTH-1:0]   r_start,  n_start;
    logic [LEN_W-1:0]       r_len,    n_len;
    logic [KW_BITS-1:0]     r_recent, n_recent;
    logic [VALUE_WIDTH-1:0] r_acc,    n_acc;

    // Token queue
    ctok_pkg::t_token       r_q [ctok_pkg::QUEUE_DEPTH];
    logic [QPTR_W-1:0]      r_wr, r_rd;
    logic [QCNT_W-1:0]      r_count;

    // Per-character results
    ctok_pkg::t_token       step_res [NRES];
    logic [1:0]             step_cnt;
    logic                   in_fire, out_fire;
    logic [7:0]             c;
    logic                   fin;
    logic                   c_digit, c_alpha, c_word, c_space;
    logic [VALUE_WIDTH+3:0] acc_wide;
    logic [VALUE_WIDTH-1:0] acc_next;
    logic                   fresh;

    function automatic ctok_pkg::t_token tok(
        input ctok_pkg::t_kind        kind,
        input logic [POS_WIDTH-1:0]   start,
        input logic [LEN_W-1:0]       len,
        input logic [1:0]             slot,
        input logic [VALUE_WIDTH-1:0] val
    );
        ctok_pkg::t_token t;
        logic [63:0]      s64;
        logic [63:0]      v64;
        s64            = 64'(start);
        v64            = 64'(val);
        t.kind         = kind;
        t.start_pos    = s64[ctok_pkg::START_W-1:0];
        t.length       = len;
        t.keyword_slot = slot;
        t.const_value  = v64[ctok_pkg::VALUE_W-1:0];
        t.run_end      = 1'b0;
        return t;
    endfunction

    // Identifier or keyword: masks the last characters to the token length and
    // compares against the active keyword slots, lowest slot winning.
    function automatic ctok_pkg::t_token ident_tok(
        input logic [POS_WIDTH-1:0] start,
        input logic [LEN_W-1:0]     len,
        input logic [KW_BITS-1:0]   recent
    );
        logic [KW_BITS-1:0] word;
        logic               hit;
        logic [1:0]         slot;
        word = '0;
        hit  = 1'b0;
        slot = 2'd0;
        for (int b = 0; b < MAX_KEYWORD_CHARS; b++) begin
            if (LEN_W'(b) < len) begin
                word[b*8 +: 8] = recent[b*8 +: 8];
            end
        end
        if (len != '0 && len <= LEN_W'(MAX_KEYWORD_CHARS)) begin
            for (int i = KW_REGS - 1; i >= 0; i--) begin
                if (ctok_pkg::KW_COUNT_W'(i) < r_kw_count &&
                    (r_kw[i] >> KW_BITS) == '0 &&
                    r_kw[i][KW_BITS-1:0] == word) begin
                    hit  = 1'b1;
                    slot = 2'(i);
                end
            end
        end
        if (hit) begin
            return tok(ctok_pkg::KIND_KEYWORD, start, len, slot, '0);
        end
        return tok(ctok_pkg::KIND_IDENT, start, len, 2'd0, '0);
    endfunction

    function automatic logic [LEN_W-1:0] grow(input logic [LEN_W-1:0] len);
        return (len != '1) ? len + 1'b1 : len;
    endfunction

    // Handshakes and character classes
    assign in_fire  = i_in.valid && i_in.ready;
    assign out_fire = o_out.valid && o_out.ready;
    assign c        = i_in.ch;
    assign fin      = i_in.final_char;
    assign c_digit  = (c >= ctok_pkg::CH_ZERO) && (c <= ctok_pkg::CH_NINE);
    assign c_alpha  = ((c >= ctok_pkg::CH_LOW_A) && (c <= ctok_pkg::CH_LOW_Z)) ||
                      ((c >= ctok_pkg::CH_UP_A) && (c <= ctok_pkg::CH_UP_Z));
    assign c_word   = c_alpha || c_digit || (c == ctok_pkg::CH_UNDER);
    assign c_space  = (c == ctok_pkg::CH_SPACE) || (c == ctok_pkg::CH_TAB) ||
                      (c == ctok_pkg::CH_LF);

    // Saturating decimal accumulate: 10 * acc + digit, clipped at all ones
    assign acc_wide = ((VALUE_WIDTH+4)'(r_acc) << 3) + ((VALUE_WIDTH+4)'(r_acc) << 1) +
                      (VALUE_WIDTH+4)'(c[3:0]);
    assign acc_next = (acc_wide[VALUE_WIDTH+3:VALUE_WIDTH] != '0) ? '1 :
                      acc_wide[VALUE_WIDTH-1:0];

    // Scanner step for the offered character
    always_comb begin
        n_mode   = r_mode;
        n_pos    = r_pos;
        n_start  = r_start;
        n_len    = r_len;
        n_recent = r_recent;
        n_acc    = r_acc;
        fresh    = 1'b0;
        step_cnt = 2'd0;
        for (int k = 0; k < NRES; k++) begin
            step_res[k] = '0;
        end

        // Continue the token or comment in progress
        case (r_mode)
            MODE_IDENT: begin
                if (c_word) begin
                    n_len    = grow(r_len);
                    n_recent = (r_recent << 8) | KW_BITS'(c);
                end else begin
                    step_res[step_cnt] = ident_tok(r_start, r_len, r_recent);
                    step_cnt = step_cnt + 2'd1;
                    n_mode   = MODE_NORMAL;
                    fresh    = 1'b1;
                end
            end
            MODE_NUMBER: begin
                if (c_digit) begin
                    n_len = grow(r_len);
                    n_acc = acc_next;
                end else if (c_word) begin
                    step_res[step_cnt] = tok(ctok_pkg::KIND_BADNUM, r_start, grow(r_len),
                                             2'd0, '0);
                    step_cnt = step_cnt + 2'd1;
                    n_mode   = MODE_ERROR;
                end else begin
                    step_res[step_cnt] = tok(ctok_pkg::KIND_CONST, r_start, r_len,
                                             2'd0, r_acc);
                    step_cnt = step_cnt + 2'd1;
                    n_mode   = MODE_NORMAL;
                    fresh    = 1'b1;
                end
            end
            MODE_SLASH: begin
                if (c == ctok_pkg::CH_SLASH) begin
                    n_mode = MODE_LINE;
                end else if (c == ctok_pkg::CH_STAR) begin
                    n_mode = MODE_BLOCK;
                end else begin
                    step_res[step_cnt] = tok(ctok_pkg::KIND_BADCHAR, r_start, LEN_W'(1),
                                             2'd0, '0);
                    step_cnt = step_cnt + 2'd1;
                    n_mode   = MODE_ERROR;
                end
            end
            MODE_LINE: begin
                if (c == ctok_pkg::CH_LF) begin
                    n_mode = MODE_NORMAL;
                end
            end
            MODE_BLOCK: begin
                if (c == ctok_pkg::CH_STAR) begin
                    n_mode = MODE_BSTAR;
                end
            end
            MODE_BSTAR: begin
                if (c == ctok_pkg::CH_SLASH) begin
                    n_mode = MODE_NORMAL;
                end else if (c != ctok_pkg::CH_STAR) begin
                    n_mode = MODE_BLOCK;
                end
            end
            MODE_ERROR: begin
                n_mode = MODE_ERROR;
            end
            default: begin
                fresh = 1'b1;
            end
        endcase

        // Start of a new token between tokens
        if (fresh) begin
            if (c_space) begin
                n_mode = MODE_NORMAL;
            end else if (c == ctok_pkg::CH_SEMI) begin
                step_res[step_cnt] = tok(ctok_pkg::KIND_SEMI, r_pos, LEN_W'(1), 2'd0, '0);
                step_cnt = step_cnt + 2'd1;
            end else if (c == ctok_pkg::CH_LBRACE) begin
                step_res[step_cnt] = tok(ctok_pkg::KIND_LBRACE, r_pos, LEN_W'(1), 2'd0, '0);
                step_cnt = step_cnt + 2'd1;
            end else if (c == ctok_pkg::CH_RBRACE) begin
                step_res[step_cnt] = tok(ctok_pkg::KIND_RBRACE, r_pos, LEN_W'(1), 2'd0, '0);
                step_cnt = step_cnt + 2'd1;
            end else if (c == ctok_pkg::CH_LPAREN) begin
                step_res[step_cnt] = tok(ctok_pkg::KIND_LPAREN, r_pos, LEN_W'(1), 2'd0, '0);
                step_cnt = step_cnt + 2'd1;
            end else if (c == ctok_pkg::CH_RPAREN) begin
                step_res[step_cnt] = tok(ctok_pkg::KIND_RPAREN, r_pos, LEN_W'(1), 2'd0, '0);
                step_cnt = step_cnt + 2'd1;
            end else if (c == ctok_pkg::CH_SLASH) begin
                n_mode  = MODE_SLASH;
                n_start = r_pos;
                n_len   = LEN_W'(1);
            end else if (c_digit) begin
                n_mode  = MODE_NUMBER;
                n_start = r_pos;
                n_len   = LEN_W'(1);
                n_acc   = VALUE_WIDTH'(c[3:0]);
            end else if (c_word) begin
                n_mode   = MODE_IDENT;
                n_start  = r_pos;
                n_len    = LEN_W'(1);
                n_recent = KW_BITS'(c);
            end else begin
                step_res[step_cnt] = tok(ctok_pkg::KIND_BADCHAR, r_pos, LEN_W'(1), 2'd0, '0);
                step_cnt = step_cnt + 2'd1;
                n_mode   = MODE_ERROR;
            end
        end

        // Last character: flush the pending token, close with the end token
        if (fin) begin
            if (n_mode == MODE_IDENT) begin
                step_res[step_cnt] = ident_tok(n_start, n_len, n_recent);
                step_cnt = step_cnt + 2'd1;
            end else if (n_mode == MODE_NUMBER) begin
                step_res[step_cnt] = tok(ctok_pkg::KIND_CONST, n_start, n_len, 2'd0, n_acc);
                step_cnt = step_cnt + 2'd1;
            end else if (n_mode == MODE_SLASH) begin
                step_res[step_cnt] = tok(ctok_pkg::KIND_BADCHAR, n_start, LEN_W'(1),
                                         2'd0, '0);
                step_cnt = step_cnt + 2'd1;
            end
            step_res[step_cnt] = tok(ctok_pkg::KIND_END, r_pos + 1'b1, '0, 2'd0, '0);
            step_cnt = step_cnt + 2'd1;
            n_mode   = MODE_NORMAL;
            n_pos    = '0;
            n_start  = '0;
            n_len    = '0;
            n_recent = '0;
            n_acc    = '0;
        end else begin
            n_pos = r_pos + 1'b1;
        end

        // Mark the last token of this character
        for (int k = 0; k < NRES; k++) begin
            step_res[k].run_end = (2'(k + 1) == step_cnt);
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kw_count <= '0;
            for (int i = 0; i < KW_REGS; i++) begin
                r_kw[i] <= '0;
            end
        end else if (i_cfg_we) begin
            if (i_cfg_idx == ctok_pkg::REG_KEYWORD_COUNT) begin
                r_kw_count <= i_cfg_data[ctok_pkg::KW_COUNT_W-1:0];
            end
            for (int i = 0; i < KW_REGS; i++) begin
                if (i_cfg_idx == ctok_pkg::REG_KEYWORD_A + ctok_pkg::CFG_IDX_W'(i)) begin
                    r_kw[i] <= i_cfg_data;
                end
            end
        end
    end

    // Scanner state update on each accepted character
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_NORMAL;
            r_pos    <= '0;
            r_start  <= '0;
            r_len    <= '0;
            r_recent <= '0;
            r_acc    <= '0;
        end else if (in_fire) begin
            r_mode   <= n_mode;
            r_pos    <= n_pos;
            r_start  <= n_start;
            r_len    <= n_len;
            r_recent <= n_recent;
            r_acc    <= n_acc;
        end
    end

    // Token queue storage
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NRES; k++) begin
            if (in_fire && 2'(k) < step_cnt) begin
                r_q[r_wr + QPTR_W'(k)] <= step_res[k];
            end
        end
    end

    // Token queue pointers and fill
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (in_fire) begin
                r_wr <= r_wr + QPTR_W'(step_cnt);
            end
            if (out_fire) begin
                r_rd <= r_rd + 1'b1;
            end
            r_count <= r_count + (in_fire ? QCNT_W'(step_cnt) : '0) -
                       (out_fire ? QCNT_W'(1) : '0);
        end
    end

    // Channel outputs
    assign i_in.ready         = (r_count <= QCNT_W'(ctok_pkg::QUEUE_DEPTH - NRES));
    assign o_out.valid        = (r_count != '0);
    assign o_out.kind         = r_q[r_rd].kind;
    assign o_out.start_pos    = r_q[r_rd].start_pos;
    assign o_out.length       = r_q[r_rd].length;
    assign o_out.keyword_slot = r_q[r_rd].keyword_slot;
    assign o_out.const_value  = r_q[r_rd].const_value;
    assign o_out.run_end      = r_q[r_rd].run_end;

    // The queue never overfills
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(ctok_pkg::QUEUE_DEPTH))
        else $error("token queue fill beyond its depth");

    // The last character always yields at least the end token
    a_final_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && fin) |-> (step_cnt != 2'd0))
        else $error("final character produced no token");

    // After the last character the scanner is back at the start of a text
    a_final_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && fin) |=> (r_mode == MODE_NORMAL && r_pos == '0))
        else $error("scanner not restarted after final character");

    // An end token always closes its character's run
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.kind == ctok_pkg::KIND_END) |-> o_out.run_end)
        else $error("end token not marked as last of its run");

endmodule

### tb/ctok_checker.sv
// Token predictor and scoreboard for the C subset tokenizer.
module ctok_checker
    import ctok_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    ctok_in_if                    in_mon,
    ctok_out_if                   out_mon,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_tokens_due,
    output int                    o_tokens_checked,
    output int                    o_keyword_hits
);

    // Scanner modes between characters.
    typedef enum logic [2:0] {
        LEX_NORMAL,
        LEX_SLASH,
        LEX_LINE,
        LEX_BLOCK,
        LEX_STAR,
        LEX_IDENT,
        LEX_NUMBER,
        LEX_DISCARD
    } t_lex;

    localparam int               REPORT_LIMIT = 10;
    localparam logic [VALUE_W-1:0] VALUE_MAX  = '1;
    localparam logic [LEN_W-1:0]   LEN_MAX    = '1;

    // Configuration copy.
    logic [KW_COUNT_W-1:0] kw_count;
    logic [CFG_DATA_W-1:0] kw_word [KEYWORD_REGS];

    // Scanner state copy.
    t_lex               lex_mode;
    logic [START_W-1:0] char_pos;
    logic [START_W-1:0] tok_start;
    logic [LEN_W-1:0]   tok_len;
    logic [63:0]        word_bytes;
    logic [VALUE_W-1:0] num_value;

    t_token token_fifo[$];   // expected tokens, oldest first
    t_token char_tokens[$];  // tokens raised by the character being scanned

    int fail_cnt;
    int checked_cnt;
    int kw_hits;

    function automatic bit is_digit_ch(logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic bit is_alpha_ch(logic [7:0] c);
        return (c >= CH_LOW_A && c <= CH_LOW_Z) || (c >= CH_UP_A && c <= CH_UP_Z);
    endfunction

    function automatic bit is_word_ch(logic [7:0] c);
        return is_alpha_ch(c) || is_digit_ch(c) || c == CH_UNDER;
    endfunction

    function automatic logic [LEN_W-1:0] len_plus(logic [LEN_W-1:0] n);
        return (n == LEN_MAX) ? n : n + 1'b1;
    endfunction

    function automatic void emit(t_kind k, logic [START_W-1:0] s, logic [LEN_W-1:0] n,
                                 logic [SLOT_W-1:0] slot, logic [VALUE_W-1:0] v);
        t_token t;
        t.kind         = k;
        t.start_pos    = s;
        t.length       = n;
        t.keyword_slot = slot;
        t.const_value  = v;
        t.run_end      = 1'b0;
        char_tokens.insert(char_tokens.size(), t);
    endfunction

    // An identifier is a keyword when its last bytes match an active slot;
    // scanning downward leaves the lowest matching slot.
    function automatic void emit_word();
        int          active;
        int          n;
        int          i;
        int          slot;
        bit          hit;
        logic [63:0] mask;
        active = (kw_count > KEYWORD_REGS) ? KEYWORD_REGS : kw_count;
        n      = tok_len;
        hit    = 1'b0;
        slot   = 0;
        if (n >= 1 && n <= DEF_MAX_KEYWORD_CHARS) begin
            mask = (n == 8) ? '1 : ((64'd1 << (8 * n)) - 64'd1);
            for (i = active - 1; i >= 0; i--) begin
                if (kw_word[i] == (word_bytes & mask)) begin
                    hit  = 1'b1;
                    slot = i;
                end
            end
        end
        if (hit) begin
            emit(KIND_KEYWORD, tok_start, tok_len, SLOT_W'(slot), '0);
        end else begin
            emit(KIND_IDENT, tok_start, tok_len, '0, '0);
        end
    endfunction

    // Advance the scanner by one character and queue the tokens it completes.
    function automatic void scan_char(logic [7:0] c, logic fin);
        logic [START_W-1:0] here;
        logic [VALUE_W-1:0] digit;
        bit                 fresh;
        here  = char_pos;
        fresh = 1'b0;
        char_tokens.delete();

        case (lex_mode)
            LEX_IDENT: begin
                if (is_word_ch(c)) begin
                    tok_len    = len_plus(tok_len);
                    word_bytes = {word_bytes[55:0], c};
                end else begin
                    emit_word();
                    lex_mode = LEX_NORMAL;
                    fresh    = 1'b1;
                end
            end
            LEX_NUMBER: begin
                if (is_digit_ch(c)) begin
                    digit   = VALUE_W'(c - CH_ZERO);
                    tok_len = len_plus(tok_len);
                    if (num_value > (VALUE_MAX - digit) / 10) begin
                        num_value = VALUE_MAX;
                    end else begin
                        num_value = num_value * 10 + digit;
                    end
                end else if (is_word_ch(c)) begin
                    emit(KIND_BADNUM, tok_start, len_plus(tok_len), '0, '0);
                    lex_mode = LEX_DISCARD;
                end else begin
                    emit(KIND_CONST, tok_start, tok_len, '0, num_value);
                    lex_mode = LEX_NORMAL;
                    fresh    = 1'b1;
                end
            end
            LEX_SLASH: begin
                if (c == CH_SLASH) begin
                    lex_mode = LEX_LINE;
                end else if (c == CH_STAR) begin
                    lex_mode = LEX_BLOCK;
                end else begin
                    emit(KIND_BADCHAR, tok_start, LEN_W'(1), '0, '0);
                    lex_mode = LEX_DISCARD;
                end
            end
            LEX_LINE: begin
                if (c == CH_LF) lex_mode = LEX_NORMAL;
            end
            LEX_BLOCK: begin
                if (c == CH_STAR) lex_mode = LEX_STAR;
            end
            LEX_STAR: begin
                if (c == CH_SLASH) begin
                    lex_mode = LEX_NORMAL;
                end else if (c != CH_STAR) begin
                    lex_mode = LEX_BLOCK;
                end
            end
            LEX_DISCARD: begin
            end
            default: begin
                fresh = 1'b1;
            end
        endcase

        // Character seen between tokens.
        if (fresh) begin
            case (c)
                CH_SPACE, CH_TAB, CH_LF: begin
                end
                CH_SEMI:   emit(KIND_SEMI, here, LEN_W'(1), '0, '0);
                CH_LBRACE: emit(KIND_LBRACE, here, LEN_W'(1), '0, '0);
                CH_RBRACE: emit(KIND_RBRACE, here, LEN_W'(1), '0, '0);
                CH_LPAREN: emit(KIND_LPAREN, here, LEN_W'(1), '0, '0);
                CH_RPAREN: emit(KIND_RPAREN, here, LEN_W'(1), '0, '0);
                CH_SLASH: begin
                    lex_mode  = LEX_SLASH;
                    tok_start = here;
                    tok_len   = LEN_W'(1);
                end
                default: begin
                    if (is_digit_ch(c)) begin
                        lex_mode  = LEX_NUMBER;
                        tok_start = here;
                        tok_len   = LEN_W'(1);
                        num_value = VALUE_W'(c - CH_ZERO);
                    end else if (is_alpha_ch(c) || c == CH_UNDER) begin
                        lex_mode   = LEX_IDENT;
                        tok_start  = here;
                        tok_len    = LEN_W'(1);
                        word_bytes = 64'(c);
                    end else begin
                        emit(KIND_BADCHAR, here, LEN_W'(1), '0, '0);
                        lex_mode = LEX_DISCARD;
                    end
                end
            endcase
        end

        // The last character flushes any open token and closes the text.
        if (fin) begin
            if (lex_mode == LEX_IDENT) begin
                emit_word();
            end else if (lex_mode == LEX_NUMBER) begin
                emit(KIND_CONST, tok_start, tok_len, '0, num_value);
            end else if (lex_mode == LEX_SLASH) begin
                emit(KIND_BADCHAR, tok_start, LEN_W'(1), '0, '0);
            end
            emit(KIND_END, here + 1'b1, '0, '0, '0);
            lex_mode   = LEX_NORMAL;
            char_pos   = '0;
            tok_start  = '0;
            tok_len    = '0;
            word_bytes = '0;
            num_value  = '0;
        end else begin
            char_pos = here + 1'b1;
        end

        if (char_tokens.size() > 0) begin
            char_tokens[char_tokens.size() - 1].run_end = 1'b1;
        end
        foreach (char_tokens[i]) begin
            if (char_tokens[i].kind == KIND_KEYWORD) kw_hits++;
            token_fifo.insert(token_fifo.size(), char_tokens[i]);
        end
    endfunction

    // Compare one token beat against the oldest expectation.
    function automatic void check_beat();
        t_token got;
        t_token want;
        got.kind         = t_kind'(out_mon.kind);
        got.start_pos    = out_mon.start_pos;
        got.length       = out_mon.length;
        got.keyword_slot = out_mon.keyword_slot;
        got.const_value  = out_mon.const_value;
        got.run_end      = out_mon.run_end;
        if (token_fifo.size() == 0) begin
            fail_cnt++;
            if (fail_cnt <= REPORT_LIMIT) begin
                $display("Unexpected token: kind %0d start %0d len %0d slot %0d val %0d last %0b",
                         got.kind, got.start_pos, got.length, got.keyword_slot,
                         got.const_value, got.run_end);
            end
        end else begin
            want = token_fifo.pop_front();
            checked_cnt++;
            if (got.kind !== want.kind || got.start_pos !== want.start_pos ||
                got.length !== want.length || got.keyword_slot !== want.keyword_slot ||
                got.const_value !== want.const_value || got.run_end !== want.run_end) begin
                fail_cnt++;
                if (fail_cnt <= REPORT_LIMIT) begin
                    $display("Token %0d mismatch:", checked_cnt);
                    $display("  expected kind %0d start %0d len %0d slot %0d val %0d last %0b",
                             want.kind, want.start_pos, want.length,
                             want.keyword_slot, want.const_value, want.run_end);
                    $display("  actual   kind %0d start %0d len %0d slot %0d val %0d last %0b",
                             got.kind, got.start_pos, got.length, got.keyword_slot,
                             got.const_value, got.run_end);
                end
            end
        end
    endfunction

    initial begin
        fail_cnt    = 0;
        checked_cnt = 0;
        kw_hits     = 0;
    end

    // Follow configuration writes and both channels at every edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            kw_count   = '0;
            foreach (kw_word[i]) kw_word[i] = '0;
            lex_mode   = LEX_NORMAL;
            char_pos   = '0;
            tok_start  = '0;
            tok_len    = '0;
            word_bytes = '0;
            num_value  = '0;
            token_fifo.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_KEYWORD_COUNT) begin
                    kw_count = i_cfg_data[KW_COUNT_W-1:0];
                end else if (i_cfg_idx >= REG_KEYWORD_A &&
                             i_cfg_idx < REG_KEYWORD_A + KEYWORD_REGS) begin
                    kw_word[i_cfg_idx - REG_KEYWORD_A] = i_cfg_data;
                end
            end
            if (in_mon.valid && in_mon.ready) scan_char(in_mon.ch, in_mon.final_char);
            if (out_mon.valid && out_mon.ready) check_beat();
        end
        o_fail_count     <= fail_cnt;
        o_tokens_due     <= token_fifo.size();
        o_tokens_checked <= checked_cnt;
        o_keyword_hits   <= kw_hits;
    end

endmodule

### tb/tb_c_subset_tokenizer.sv
// Testbench top for the C subset tokenizer: clock, reset, stimulus and verdict.
module tb_c_subset_tokenizer;
    import ctok_pkg::*;

    localparam int RUN_LIMIT     = 600000;
    localparam int RANDOM_CHARS  = 280;
    localparam int HOLD_CYCLES   = 200;
    localparam int SETTLE_CYCLES = 6;
    localparam int TEXTS_PER_SET = 5;
    localparam int MAX_GAP       = 5;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    ctok_in_if  in_ch ();
    ctok_out_if out_ch ();

    int fail_count;
    int tokens_due;
    int tokens_checked;
    int keyword_hits;

    logic [7:0]            text_buf[$];
    string                 kw_text [KEYWORD_REGS];
    logic [CFG_DATA_W-1:0] kw_value[KEYWORD_REGS];

    int chars_sent    = 0;
    int texts_sent    = 0;
    int settings_used = 0;
    int cycle_count   = 0;
    bit calm_in       = 1'b0;
    bit calm_out      = 1'b0;
    bit hold_req      = 1'b0;
    bit hold_done     = 1'b0;

    c_subset_tokenizer u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    ctok_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .in_mon           (in_ch),
        .out_mon          (out_ch),
        .i_cfg_we         (cfg_we),
        .i_cfg_idx        (cfg_idx),
        .i_cfg_data       (cfg_data),
        .o_fail_count     (fail_count),
        .o_tokens_due     (tokens_due),
        .o_tokens_checked (tokens_checked),
        .o_keyword_hits   (keyword_hits)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Keywords are packed with the last character in the low byte.
    function automatic logic [CFG_DATA_W-1:0] pack_word(string s);
        logic [CFG_DATA_W-1:0] w;
        w = '0;
        for (int i = 0; i < s.len(); i++) w = {w[CFG_DATA_W-9:0], 8'(s[i])};
        return w;
    endfunction

    function automatic string rand_letters(int n);
        string s;
        s = "";
        repeat (n) s = {s, string'(8'($urandom_range(CH_LOW_A, CH_LOW_Z)))};
        return s;
    endfunction

    function automatic logic [7:0] rand_word_char(bit lead);
        int pick;
        pick = lead ? $urandom_range(0, 52) : $urandom_range(0, 62);
        if (pick < 26) return CH_LOW_A + 8'(pick);
        if (pick < 52) return CH_UP_A + 8'(pick - 26);
        if (pick == 52) return CH_UNDER;
        return CH_ZERO + 8'(pick - 53);
    endfunction

    // Add one byte at the tail of the text being built.
    function automatic void append_byte(logic [7:0] b);
        text_buf.insert(text_buf.size(), b);
    endfunction

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++) append_byte(8'(s[i]));
    endfunction

    function automatic void add_blank();
        case ($urandom_range(0, 2))
            0:       append_byte(CH_SPACE);
            1:       append_byte(CH_TAB);
            default: append_byte(CH_LF);
        endcase
    endfunction

    // Identifier: often a configured keyword, sometimes stretched past it.
    function automatic void add_word();
        int k;
        int n;
        k = $urandom_range(0, KEYWORD_REGS - 1);
        if ($urandom_range(0, 1) == 1 && kw_text[k] != "") begin
            add_text(kw_text[k]);
            if ($urandom_range(0, 3) == 0) append_byte(rand_word_char(1'b0));
        end else begin
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 14) : $urandom_range(1, 9);
            append_byte(rand_word_char(1'b1));
            repeat (n - 1) append_byte(rand_word_char(1'b0));
        end
    endfunction

    // Decimal constant: short ones mostly, long ones to reach saturation.
    function automatic void add_number();
        int n;
        case ($urandom_range(0, 9))
            0: add_text("4294967295");
            1: add_text("4294967296");
            default: begin
                n = ($urandom_range(0, 6) == 0) ? $urandom_range(10, 14) : $urandom_range(1, 4);
                repeat (n) append_byte(CH_ZERO + 8'($urandom_range(0, 9)));
            end
        endcase
    endfunction

    function automatic void add_punct();
        case ($urandom_range(0, 4))
            0:       append_byte(CH_SEMI);
            1:       append_byte(CH_LBRACE);
            2:       append_byte(CH_RBRACE);
            3:       append_byte(CH_LPAREN);
            default: append_byte(CH_RPAREN);
        endcase
    endfunction

    // Comment bodies carry arbitrary bytes; block bodies favor stars and slashes.
    function automatic void add_comment(bit block);
        logic [7:0] b;
        append_byte(CH_SLASH);
        append_byte(block ? CH_STAR : CH_SLASH);
        repeat ($urandom_range(0, 6)) begin
            case ($urandom_range(0, 3))
                0:       b = block ? CH_STAR : CH_SPACE;
                1:       b = block ? CH_SLASH : CH_STAR;
                default: b = 8'($urandom_range(0, 255));
            endcase
            if (!block && b == CH_LF) b = CH_SPACE;
            append_byte(b);
        end
        if ($urandom_range(0, 5) != 0) begin
            if (block) begin
                append_byte(CH_STAR);
                append_byte(CH_SLASH);
            end else begin
                append_byte(CH_LF);
            end
        end
    endfunction

    // Broken input: lone slash, stray byte, or digits running into a letter.
    function automatic void add_fault();
        case ($urandom_range(0, 3))
            0: begin
                append_byte(CH_SLASH);
                append_byte(rand_word_char(1'b1));
            end
            1: append_byte(8'($urandom_range(128, 255)));
            2: begin
                case ($urandom_range(0, 3))
                    0:       append_byte(8'h0D);  // carriage return
                    1:       append_byte(8'h00);  // NUL
                    2:       add_text("#");
                    default: add_text("+");
                endcase
            end
            default: begin
                add_number();
                append_byte(rand_word_char(1'b1));
            end
        endcase
    endfunction

    // One random source text: mostly well-formed pieces, a little raw noise.
    function automatic void build_random_text();
        int pick;
        text_buf.delete();
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 8)) append_byte(8'($urandom_range(0, 255)));
        end else begin
            repeat ($urandom_range(1, 8)) begin
                pick = $urandom_range(0, 99);
                if (pick < 24)      add_word();
                else if (pick < 38) add_number();
                else if (pick < 60) add_punct();
                else if (pick < 72) add_blank();
                else if (pick < 80) add_comment(1'b0);
                else if (pick < 95) add_comment(1'b1);
                else                add_fault();
                if ($urandom_range(0, 4) != 0) add_blank();
            end
        end
    endfunction

    // Offer one character beat after a random gap and wait for it to be taken.
    task automatic send_beat(input logic [7:0] c, input logic fin);
        int gap;
        gap = calm_in ? 0 : $urandom_range(0, MAX_GAP);
        if ($urandom_range(0, 39) == 0) calm_in = !calm_in;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.ch         <= c;
        in_ch.final_char <= fin;
        do @(posedge i_clk); while (!(in_ch.valid && in_ch.ready));
        chars_sent++;
    endtask

    // Send the buffered text, with the end marker on its last character.
    task automatic send_text();
        for (int i = 0; i < text_buf.size(); i++) begin
            send_beat(text_buf[i], i == text_buf.size() - 1);
        end
        texts_sent++;
    endtask

    task automatic send_string(input string s);
        text_buf.delete();
        add_text(s);
        send_text();
    endtask

    // Stop offering, then wait until every predicted token has come out.
    task automatic settle();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (tokens_due != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0]  idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
    endtask

    // Write every register, plus one index past the keyword slots.
    task automatic load_keywords(input logic [KW_COUNT_W-1:0] count);
        cfg_write(REG_KEYWORD_COUNT, {$urandom, 29'($urandom), count});
        for (int i = 0; i < KEYWORD_REGS; i++) begin
            cfg_write(CFG_IDX_W'(REG_KEYWORD_A + i), kw_value[i]);
        end
        cfg_write(CFG_IDX_W'(REG_KEYWORD_A + KEYWORD_REGS), '1);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic use_words(input string a, input string b, input string c, input string d);
        kw_text[0] = a;
        kw_text[1] = b;
        kw_text[2] = c;
        kw_text[3] = d;
        foreach (kw_text[i]) kw_value[i] = pack_word(kw_text[i]);
    endtask

    // Token receiver: random stalls, calm stretches and one long hold-off.
    initial begin
        int stall;
        out_ch.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (hold_req && !hold_done) begin
                stall     = HOLD_CYCLES;
                hold_done = 1'b1;
            end else begin
                stall = calm_out ? 0 : $urandom_range(0, MAX_GAP);
            end
            if ($urandom_range(0, 39) == 0) calm_out = !calm_out;
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(out_ch.valid && out_ch.ready));
        end
    end

    // Watchdog.
    initial begin
        while (cycle_count < RUN_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles with %0d tokens outstanding",
                 cycle_count, tokens_due);
        $display("[FAIL] regression broken");
        $finish;
    end

    // Stimulus and verdict.
    initial begin
        int directed_chars;
        int set_idx;
        i_rst_n          <= 1'b0;
        in_ch.valid      <= 1'b0;
        in_ch.ch         <= '0;
        in_ch.final_char <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_idx          <= '0;
        cfg_data         <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: duplicate keyword, block close after "/*/", bad number,
        // lone slash mid-text and at the end, extreme bytes, open comment.
        use_words("if", "if", "while", "abcdefgh");
        load_keywords(KW_COUNT_W'(KEYWORD_REGS));
        send_string("if(7){x}");
        send_string("/*/*/3");
        send_string("1a/");
        send_string("/ ");
        send_string("/");
        text_buf.delete();
        append_byte(8'hFF);
        send_text();
        text_buf.delete();
        append_byte(8'h00);
        send_text();
        send_string("/*");
        settle();
        directed_chars = chars_sent;

        // Random texts, rotating through keyword settings.
        set_idx = 0;
        while (chars_sent - directed_chars < RANDOM_CHARS) begin
            case (set_idx % 4)
                0: begin
                    use_words("int", "return", "x", "abcdefgh");
                    load_keywords('1);
                end
                1: load_keywords('0);
                2: begin
                    use_words("", "do", "", "while");
                    kw_value[0] = '1;
                    load_keywords(KW_COUNT_W'(2));
                end
                default: begin
                    use_words(rand_letters($urandom_range(1, 8)),
                              rand_letters($urandom_range(1, 8)),
                              rand_letters($urandom_range(1, 3)), rand_letters(8));
                    load_keywords(KW_COUNT_W'($urandom_range(1, KEYWORD_REGS)));
                end
            endcase
            for (int t = 0; t < TEXTS_PER_SET; t++) begin
                if (set_idx == 0 && t == 1) hold_req <= 1'b1;
                build_random_text();
                send_text();
            end
            settle();
            set_idx++;
        end

        $display("Fed %0d characters in %0d texts under %0d keyword settings.",
                 chars_sent, texts_sent, settings_used);
        $display("Checked %0d tokens (%0d keywords) across random stalls and one long hold-off.",
                 tokens_checked, keyword_hits);
        if (fail_count == 0 && tokens_due == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches, %0d tokens never arrived", fail_count, tokens_due);
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

### c_subset_tokenizer.f
rtl/ctok_pkg.sv
rtl/ctok_in_if.sv
rtl/ctok_out_if.sv
rtl/c_subset_tokenizer.sv
tb/ctok_checker.sv
tb/tb_c_subset_tokenizer.sv
